[hdl/lmps_pkg.sv]
package lmps_pkg;

  // Default geometry of the matrix.
  localparam int COLUMNS_DEF  = 8;
  localparam int CHANNELS_DEF = 15;

  // Fixed field widths of the streaming ports.
  localparam int OP_W       = 2;
  localparam int COORD_W    = 3;
  localparam int BYTE_W     = 8;
  localparam int DRIVE_W    = 15;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // A column lasts until the tick count reaches this value.
  localparam logic [3:0] TICK_LAST = 4'd15;
  // Largest counter value that still lights its channel.
  localparam logic [BYTE_W-1:0] PWM_MAX = 8'd15;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHIFT = 2'd1,
    ACT_RESET = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_TICK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

[hdl/lmps_ram.sv]
module lmps_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/lmps_seq.sv]
module lmps_seq #(
  parameter int COLUMNS  = lmps_pkg::COLUMNS_DEF,
  parameter int CHANNELS = lmps_pkg::CHANNELS_DEF,
  parameter int AW       = $clog2(COLUMNS * CHANNELS),
  parameter int CW       = $clog2(CHANNELS)
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input transaction
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lmps_pkg::op_t                 in_op,
  input  logic [lmps_pkg::COORD_W-1:0]  in_column,
  input  logic [lmps_pkg::COORD_W-1:0]  in_row,
  input  logic [lmps_pkg::BYTE_W-1:0]   in_red,
  input  logic [lmps_pkg::BYTE_W-1:0]   in_blue,
  input  logic [lmps_pkg::BYTE_W-1:0]   in_green,
  // Result toward the output register
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [CHANNELS-1:0]           res_drive,
  output lmps_pkg::act_t                res_action,
  // Frame store port
  output logic                          fs_we,
  output logic [AW-1:0]                 fs_waddr,
  output logic [lmps_pkg::BYTE_W-1:0]   fs_wdata,
  output logic                          fs_re,
  output logic [AW-1:0]                 fs_raddr,
  input  logic [lmps_pkg::BYTE_W-1:0]   fs_rdata,
  // Channel counter port
  output logic                          cnt_we,
  output logic [CW-1:0]                 cnt_waddr,
  output logic [lmps_pkg::BYTE_W-1:0]   cnt_wdata,
  output logic                          cnt_re,
  output logic [CW-1:0]                 cnt_raddr,
  input  logic [lmps_pkg::BYTE_W-1:0]   cnt_rdata
);

  localparam int DEPTH = COLUMNS * CHANNELS;
  localparam int COLW  = $clog2(COLUMNS);

  lmps_pkg::state_t state, state_next;

  logic [AW-1:0]                sweep;
  logic                         sweep_rst;
  logic                         sweep_last;
  logic [COLW-1:0]              col_idx;
  logic [AW-1:0]                frame_base;
  logic [AW-1:0]                rd_base;
  logic [3:0]                   tick_count;
  logic                         reload;
  logic [CW-1:0]                chan;
  logic                         p_valid;
  logic [CW-1:0]                p_idx;
  logic [CHANNELS-1:0]          drive;
  lmps_pkg::act_t               action;
  logic [AW-1:0]                wr_addr;
  logic [1:0]                   wr_k;
  logic [lmps_pkg::BYTE_W-1:0]  wr_red;
  logic [lmps_pkg::BYTE_W-1:0]  wr_blue;
  logic [lmps_pkg::BYTE_W-1:0]  wr_green;
  logic                         accept;
  logic                         wr_ok;
  logic [AW-1:0]                wr_base;
  logic [lmps_pkg::BYTE_W-1:0]  cur;

  assign accept     = in_valid && in_ready;
  assign sweep_last = (sweep == AW'(DEPTH - 1));

  // Range check and base address of a pixel write.
  assign wr_ok   = ({3'b000, in_column} < 6'(COLUMNS)) &&
                   ((7'(in_row) * 7'd3 + 7'd2) < 7'(CHANNELS));
  assign wr_base = AW'(AW'(in_column) * AW'(CHANNELS)) + AW'(AW'(in_row) * AW'(3));

  // Counter value in the shared unit: fresh from the store on a reload.
  assign cur = reload ? fs_rdata : cnt_rdata;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmps_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    fs_we      = 1'b0;
    fs_waddr   = wr_addr;
    fs_wdata   = '0;
    fs_re      = 1'b0;
    fs_raddr   = rd_base + AW'(chan);
    cnt_re     = 1'b0;
    cnt_raddr  = chan;
    cnt_we     = p_valid;
    cnt_waddr  = p_idx;
    cnt_wdata  = cur - 8'd1;
    case (state)
      lmps_pkg::ST_CLEAR: begin
        fs_we     = 1'b1;
        fs_waddr  = sweep;
        cnt_we    = sweep_rst && (sweep < AW'(CHANNELS));
        cnt_waddr = sweep[CW-1:0];
        cnt_wdata = '0;
        if (sweep_last) begin
          state_next = sweep_rst ? lmps_pkg::ST_IDLE : lmps_pkg::ST_FINISH;
        end
      end
      lmps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            lmps_pkg::OP_TICK:  state_next = lmps_pkg::ST_TICK;
            lmps_pkg::OP_WRITE: state_next = wr_ok ? lmps_pkg::ST_WRITE : lmps_pkg::ST_FINISH;
            lmps_pkg::OP_CLEAR: state_next = lmps_pkg::ST_CLEAR;
            default:            state_next = lmps_pkg::ST_FINISH;
          endcase
        end
      end
      lmps_pkg::ST_WRITE: begin
        fs_we = 1'b1;
        case (wr_k)
          2'd0:    fs_wdata = wr_blue;
          2'd1:    fs_wdata = wr_red;
          default: fs_wdata = wr_green;
        endcase
        if (wr_k == 2'd2) begin
          state_next = lmps_pkg::ST_FINISH;
        end
      end
      lmps_pkg::ST_TICK: begin
        fs_re  = reload;
        cnt_re = !reload;
        if (chan == CW'(CHANNELS - 1)) begin
          state_next = lmps_pkg::ST_DRAIN;
        end
      end
      lmps_pkg::ST_DRAIN: begin
        state_next = lmps_pkg::ST_FINISH;
      end
      lmps_pkg::ST_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = lmps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lmps_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer datapath: sweep, column stepping, write latch and the shared unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep      <= '0;
      sweep_rst  <= 1'b1;
      col_idx    <= '0;
      frame_base <= '0;
      tick_count <= '0;
      reload     <= 1'b0;
      chan       <= '0;
      p_valid    <= 1'b0;
      drive      <= '0;
      action     <= lmps_pkg::ACT_NONE;
      wr_k       <= '0;
    end else begin
      p_valid <= (state == lmps_pkg::ST_TICK);
      p_idx   <= chan;

      // Shared compare and decrement: one channel per cycle.
      if (p_valid) begin
        drive[p_idx] <= (cur != '0) && (cur <= lmps_pkg::PWM_MAX);
      end

      case (state)
        lmps_pkg::ST_CLEAR: begin
          sweep <= sweep_last ? '0 : sweep + AW'(1);
          if (sweep_last) begin
            sweep_rst <= 1'b0;
          end
        end
        lmps_pkg::ST_IDLE: begin
          if (accept) begin
            action <= lmps_pkg::ACT_NONE;
            chan   <= '0;
            wr_k   <= '0;
            wr_addr  <= wr_base;
            wr_red   <= in_red;
            wr_blue  <= in_blue;
            wr_green <= in_green;
            if (in_op == lmps_pkg::OP_TICK) begin
              if (tick_count == lmps_pkg::TICK_LAST) begin
                reload     <= 1'b1;
                rd_base    <= frame_base;
                tick_count <= 4'd1;
                if (col_idx == COLW'(COLUMNS - 1)) begin
                  col_idx    <= '0;
                  frame_base <= '0;
                  action     <= lmps_pkg::ACT_RESET;
                end else begin
                  col_idx    <= col_idx + COLW'(1);
                  frame_base <= frame_base + AW'(CHANNELS);
                  action     <= lmps_pkg::ACT_SHIFT;
                end
              end else begin
                reload     <= 1'b0;
                tick_count <= tick_count + 4'd1;
              end
            end
          end
        end
        lmps_pkg::ST_WRITE: begin
          wr_k    <= wr_k + 2'd1;
          wr_addr <= wr_addr + AW'(1);
        end
        lmps_pkg::ST_TICK: begin
          chan <= chan + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  assign res_drive  = drive;
  assign res_action = action;

endmodule

[hdl/led_matrix_pwm_scanner.sv]
// Multiplexed RGB matrix scanner with per-channel PWM. Each input transaction
// (tuser selects tick, pixel write or clear-all) yields exactly one output
// transaction carrying the held drive bits and the column action. A tick walks
// the channel counters through one shared compare-and-decrement unit, one
// channel per cycle; a pixel write and a clear-all both go through the single
// write port of the frame store. After reset the block zeroes the frame store
// and the counters, with s_tready low. A finished result waits in the output
// register while the next transaction is accepted.
module led_matrix_pwm_scanner #(
  parameter int COLUMNS  = lmps_pkg::COLUMNS_DEF,
  parameter int CHANNELS = lmps_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // column[2:0], row[5:3], red[13:6], blue[21:14], green[29:22], zero pad
  input  logic [lmps_pkg::IN_DATA_W-1:0]    s_tdata,
  // op[1:0]
  input  logic [lmps_pkg::OP_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // row_drive[14:0], column_action[16:15], zero pad
  output logic [lmps_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int AW = $clog2(COLUMNS * CHANNELS);
  localparam int CW = $clog2(CHANNELS);
  localparam int DW = (CHANNELS < lmps_pkg::DRIVE_W) ? CHANNELS : lmps_pkg::DRIVE_W;

  logic                          res_valid;
  logic                          res_ready;
  logic [CHANNELS-1:0]           res_drive;
  lmps_pkg::act_t                res_action;
  logic                          fs_we;
  logic [AW-1:0]                 fs_waddr;
  logic [lmps_pkg::BYTE_W-1:0]   fs_wdata;
  logic                          fs_re;
  logic [AW-1:0]                 fs_raddr;
  logic [lmps_pkg::BYTE_W-1:0]   fs_rdata;
  logic                          cnt_we;
  logic [CW-1:0]                 cnt_waddr;
  logic [lmps_pkg::BYTE_W-1:0]   cnt_wdata;
  logic                          cnt_re;
  logic [CW-1:0]                 cnt_raddr;
  logic [lmps_pkg::BYTE_W-1:0]   cnt_rdata;
  logic [lmps_pkg::DRIVE_W-1:0]  row_drive;

  lmps_seq #(
    .COLUMNS  (COLUMNS),
    .CHANNELS (CHANNELS),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (lmps_pkg::op_t'(s_tuser)),
    .in_column  (s_tdata[2:0]),
    .in_row     (s_tdata[5:3]),
    .in_red     (s_tdata[13:6]),
    .in_blue    (s_tdata[21:14]),
    .in_green   (s_tdata[29:22]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_drive  (res_drive),
    .res_action (res_action),
    .fs_we      (fs_we),
    .fs_waddr   (fs_waddr),
    .fs_wdata   (fs_wdata),
    .fs_re      (fs_re),
    .fs_raddr   (fs_raddr),
    .fs_rdata   (fs_rdata),
    .cnt_we     (cnt_we),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .cnt_re     (cnt_re),
    .cnt_raddr  (cnt_raddr),
    .cnt_rdata  (cnt_rdata)
  );

  // Frame store: COLUMNS columns of CHANNELS intensity bytes.
  lmps_ram #(
    .DEPTH (COLUMNS * CHANNELS),
    .AW    (AW),
    .DW    (lmps_pkg::BYTE_W)
  ) u_frame (
    .clk   (clk),
    .we    (fs_we),
    .waddr (fs_waddr),
    .wdata (fs_wdata),
    .re    (fs_re),
    .raddr (fs_raddr),
    .rdata (fs_rdata)
  );

  // Per-channel PWM counters.
  lmps_ram #(
    .DEPTH (CHANNELS),
    .AW    (CW),
    .DW    (lmps_pkg::BYTE_W)
  ) u_counters (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Only the low drive bits reach the port.
  assign row_drive = lmps_pkg::DRIVE_W'(res_drive[DW-1:0]);
  assign res_ready = !m_tvalid || m_tready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {7'b0000000, res_action, row_drive};
    end
  end

endmodule

[tb/led_matrix_pwm_scanner_tb.sv]
`timescale 1ns / 1ps

module led_matrix_pwm_scanner_tb;

  localparam int COLUMNS      = lmps_pkg::COLUMNS_DEF;
  localparam int CHANNELS     = lmps_pkg::CHANNELS_DEF;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 50;

  // One command to the scanner: a tick, a pixel write or a clear-all.
  typedef struct packed {
    lmps_pkg::op_t op;
    logic [2:0]    column;
    logic [2:0]    row;
    logic [7:0]    red;
    logic [7:0]    blue;
    logic [7:0]    green;
  } scan_cmd_t;

  // One output transaction: drive bits and column action.
  typedef struct {
    logic [lmps_pkg::DRIVE_W-1:0] drive;
    lmps_pkg::act_t               action;
  } scan_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [lmps_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [lmps_pkg::OP_W-1:0]       s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [lmps_pkg::OUT_DATA_W-1:0] m_tdata;

  // Predictor state: frame store, PWM counters, column and tick position.
  logic [7:0]                   frame_mem[COLUMNS*CHANNELS];
  logic [7:0]                   pwm_count[CHANNELS];
  int                           col_idx = 0;
  logic [3:0]                   tick_count = '0;
  logic [lmps_pkg::DRIVE_W-1:0] drive_hold = '0;

  scan_cmd_t    cmd_queue[$];
  scan_result_t expected_scans[$];
  scan_cmd_t    held_cmd;
  int           send_gap = 0;
  bit           send_burst = 1'b0;
  int           recv_stall = 0;
  bit           recv_burst = 1'b0;
  int           error_count = 0;
  int           cycle_count = 0;

  led_matrix_pwm_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted command to the predicted state and queue its result.
  task automatic predict_scan(input scan_cmd_t cmd);
    logic [lmps_pkg::DRIVE_W-1:0] lit;
    lmps_pkg::act_t               act;
    int                           base;
    lit = '0;
    act = lmps_pkg::ACT_NONE;
    case (cmd.op)
      lmps_pkg::OP_TICK: begin
        // A full column period has passed: load the next column.
        if (tick_count == lmps_pkg::TICK_LAST) begin
          tick_count = '0;
          for (int i = 0; i < CHANNELS; i++) pwm_count[i] = frame_mem[col_idx*CHANNELS + i];
          if (col_idx == COLUMNS - 1) begin
            col_idx = 0;
            act = lmps_pkg::ACT_RESET;
          end else begin
            col_idx++;
            act = lmps_pkg::ACT_SHIFT;
          end
        end
        for (int i = 0; i < CHANNELS; i++) begin
          if (pwm_count[i] >= 8'd1 && pwm_count[i] <= lmps_pkg::PWM_MAX) lit[i] = 1'b1;
          pwm_count[i] = pwm_count[i] - 8'd1;
        end
        drive_hold = lit;
        tick_count = tick_count + 4'd1;
      end
      lmps_pkg::OP_WRITE: begin
        // Rows without three bytes inside the column are dropped.
        if (int'(cmd.column) < COLUMNS && int'(cmd.row) * 3 + 2 < CHANNELS) begin
          base = int'(cmd.column) * CHANNELS + int'(cmd.row) * 3;
          frame_mem[base]     = cmd.blue;
          frame_mem[base + 1] = cmd.red;
          frame_mem[base + 2] = cmd.green;
        end
      end
      lmps_pkg::OP_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = '0;
      end
      default: begin
      end
    endcase
    expected_scans.push_back('{drive_hold, act});
  endtask

  task automatic push_cmd(input lmps_pkg::op_t op, input int column, input int row,
                          input int red, input int blue, input int green);
    cmd_queue.push_back('{op, 3'(column), 3'(row), 8'(red), 8'(blue), 8'(green)});
  endtask

  // Driver: presents queued commands, with random gaps between transactions.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_scan(held_cmd);
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 8);
      end
      if (s_tvalid && !s_tready) begin
        // Hold the current transaction until it is taken.
      end else if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        held_cmd = cmd_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= held_cmd.op;
        s_tdata  <= {2'b00, held_cmd.green, held_cmd.blue, held_cmd.red,
                     held_cmd.row, held_cmd.column};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction and stalls at random.
  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_scans.size() == 0) begin
          $error("unexpected result transaction: m_tdata %h", m_tdata);
          error_count++;
        end else begin
          want = expected_scans.pop_front();
          if (m_tdata[lmps_pkg::DRIVE_W-1:0] !== want.drive) begin
            $error("row_drive: expected %h, got %h", want.drive,
                   m_tdata[lmps_pkg::DRIVE_W-1:0]);
            error_count++;
          end
          if (m_tdata[lmps_pkg::DRIVE_W+1:lmps_pkg::DRIVE_W] !== want.action) begin
            $error("column_action: expected %0d, got %0d", want.action,
                   m_tdata[lmps_pkg::DRIVE_W+1:lmps_pkg::DRIVE_W]);
            error_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        recv_stall = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int pick;
    int row;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (pwm_count[i]) pwm_count[i] = '0;

    // Directed part: field extremes, ignored rows, the unused opcode,
    // the first column reload and a clear-all.
    push_cmd(lmps_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_cmd(lmps_pkg::OP_WRITE, 0, 0, 1, 15, 16);
    push_cmd(lmps_pkg::OP_WRITE, 0, 1, 0, 255, 14);
    push_cmd(lmps_pkg::OP_WRITE, 0, 4, 8'hAA, 8'h55, 8'h0F);
    push_cmd(lmps_pkg::OP_WRITE, 7, 4, 255, 255, 255);
    push_cmd(lmps_pkg::OP_WRITE, 7, 0, 0, 0, 0);
    push_cmd(lmps_pkg::OP_WRITE, 5, 5, 255, 255, 255);
    push_cmd(lmps_pkg::OP_WRITE, 2, 7, 9, 9, 9);
    push_cmd(lmps_pkg::OP_WRITE, 3, 6, 4, 4, 4);
    push_cmd(lmps_pkg::OP_NOP, 7, 7, 255, 255, 255);
    for (int i = 0; i < 15; i++) push_cmd(lmps_pkg::OP_TICK, 0, 0, 0, 0, 0);
    push_cmd(lmps_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    push_cmd(lmps_pkg::OP_TICK, 0, 0, 0, 0, 0);

    // Random part: mostly ticks and writes so columns get scanned with content.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      row  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      if (pick < 60) begin
        push_cmd(lmps_pkg::OP_TICK, $urandom_range(0, 7), row, $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 94) begin
        if ($urandom_range(0, 1) == 0)
          push_cmd(lmps_pkg::OP_WRITE, $urandom_range(0, 7), row, $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 31));
        else
          push_cmd(lmps_pkg::OP_WRITE, $urandom_range(0, 7), row, $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (pick < 96) begin
        push_cmd(lmps_pkg::OP_CLEAR, $urandom_range(0, 7), row, $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        push_cmd(lmps_pkg::OP_NOP, $urandom_range(0, 7), row, $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to be taken and every result to be checked.
    do @(negedge clk);
    while (cmd_queue.size() != 0 || s_tvalid || expected_scans.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
hdl/lmps_pkg.sv
hdl/lmps_ram.sv
hdl/lmps_seq.sv
hdl/led_matrix_pwm_scanner.sv
tb/led_matrix_pwm_scanner_tb.sv
